// ===== hdl/md5_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// md5_pkg
// Shared types, round constants and round helper functions for the MD5 engine.
// ---------------------------------------------------------------------------
package md5_pkg;

  // Padding marker byte appended after the message
  localparam logic [7:0] PAD_BYTE     = 8'h80;
  // First block word that carries the bit length
  localparam logic [3:0] LEN_WORD_LO  = 4'd14;
  localparam logic [3:0] LEN_WORD_HI  = 4'd15;
  // Byte position where the length field starts
  localparam logic [5:0] LEN_BYTE_POS = 6'd56;

  // One input item
  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_valid;
    logic       last_byte;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Control from the sequencer to the round unit
  typedef struct packed {
    logic       load;
    logic       step;
    logic [5:0] rnd;
  } rnd_ctrl_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_ADD   = 6'b001000,
    ST_PAD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  // Initial chaining value
  function automatic logic [31:0] init_word(input logic [1:0] idx);
    logic [31:0] w;
    case (idx)
      2'd0:    w = 32'h67452301;
      2'd1:    w = 32'hEFCDAB89;
      2'd2:    w = 32'h98BADCFE;
      default: w = 32'h10325476;
    endcase
    return w;
  endfunction

  // Per-round additive constant
  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Rotate amount by phase and round position within a group of four
  function automatic logic [4:0] round_shift(input logic [1:0] phase, input logic [1:0] q);
    logic [4:0] s;
    case ({phase, q})
      4'b00_00: s = 5'd7;  4'b00_01: s = 5'd12; 4'b00_10: s = 5'd17; 4'b00_11: s = 5'd22;
      4'b01_00: s = 5'd5;  4'b01_01: s = 5'd9;  4'b01_10: s = 5'd14; 4'b01_11: s = 5'd20;
      4'b10_00: s = 5'd4;  4'b10_01: s = 5'd11; 4'b10_10: s = 5'd16; 4'b10_11: s = 5'd23;
      4'b11_00: s = 5'd6;  4'b11_01: s = 5'd10; 4'b11_10: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word used in round i
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] q;
    logic [3:0] g;
    q = i[3:0];
    case (i[5:4])
      2'd0:    g = q;
      2'd1:    g = 4'(q * 4'd5 + 4'd1);
      2'd2:    g = 4'(q * 4'd3 + 4'd5);
      default: g = 4'(q * 4'd7);
    endcase
    return g;
  endfunction

  // Nonlinear mixing function of each phase
  function automatic logic [31:0] mix(input logic [1:0] phase, input logic [31:0] b,
                                     input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  // Left rotate
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/md5_hash_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bytes are taken one per cycle while idle; in_ready is low in every other state. Each full
// 64-byte block is hashed by a load, 64 rounds reading the block buffer once per round and
// a chaining add. After the last item come up to 16 padding writes and the hashing of each
// padded block (two blocks when 56 or more bytes sit in the final block), then four result
// items, one per cycle while out_ready is high.
// Reset (synchronous, rst_n low) restores the initial vector and clears the byte count.
// ---------------------------------------------------------------------------
// md5_hash_engine
// MD5 digest over a byte stream, block buffer in a synchronous memory.
// ---------------------------------------------------------------------------
module md5_hash_engine (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire md5_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output md5_pkg::out_item_t       out_data
);

  md5_pkg::state_t    state_r, state_nxt;
  logic [63:0]        cnt_r, cnt_nxt;
  logic [31:0]        wbuf_r, wbuf_nxt;
  logic [5:0]         rnd_r, rnd_nxt;
  logic [3:0]         pw_r, pw_nxt;
  logic               pfirst_r, pfirst_nxt;
  logic               len_ok_r, len_ok_nxt;
  logic               final_r, final_nxt;
  logic               pad_done_r, pad_done_nxt;
  logic [1:0]         oidx_r, oidx_nxt;
  logic [3:0][31:0]   chain_r, chain_nxt;

  logic               mem_we;
  logic [3:0]         mem_waddr;
  logic [31:0]        mem_wdata;
  logic [3:0]         mem_raddr;
  logic [31:0]        mem_rdata;

  md5_pkg::rnd_ctrl_t rctrl;
  logic [3:0][31:0]   work;

  logic               in_acc;
  logic               out_acc;
  logic [5:0]         pos;
  logic [63:0]        bit_len;
  logic [31:0]        keep_mask;
  logic [31:0]        pad_word;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;
  assign pos     = cnt_r[5:0];
  assign bit_len = {cnt_r[60:0], 3'b000};

  // block buffer
  md5_blk_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // round unit
  md5_round u_round (
    .clk        (clk),
    .ctrl       (rctrl),
    .init_words (chain_r),
    .msg_word   (mem_rdata),
    .work       (work)
  );

  // padding word: packed bytes and the marker byte first, then zeros, length in words 14 and 15
  always_comb begin
    keep_mask = ~(32'hFFFF_FFFF << {cnt_r[1:0], 3'b000});
    pad_word  = 32'd0;
    if (pfirst_r) begin
      pad_word = (wbuf_r & keep_mask) | (32'(md5_pkg::PAD_BYTE) << {cnt_r[1:0], 3'b000});
    end
    if (len_ok_r && pw_r == md5_pkg::LEN_WORD_LO) begin
      pad_word = bit_len[31:0];
    end else if (len_ok_r && pw_r == md5_pkg::LEN_WORD_HI) begin
      pad_word = bit_len[63:32];
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    wbuf_nxt     = wbuf_r;
    rnd_nxt      = rnd_r;
    pw_nxt       = pw_r;
    pfirst_nxt   = pfirst_r;
    len_ok_nxt   = len_ok_r;
    final_nxt    = final_r;
    pad_done_nxt = pad_done_r;
    oidx_nxt     = oidx_r;
    chain_nxt    = chain_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = pos[5:2];
    mem_wdata    = wbuf_nxt;
    mem_raddr    = md5_pkg::msg_index(rnd_r);
    rctrl.load   = 1'b0;
    rctrl.step   = 1'b0;
    rctrl.rnd    = rnd_r;

    case (state_r)
      md5_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          // pack the byte; a full word goes to the buffer
          if (in_data.byte_valid) begin
            if (pos[1:0] == 2'd0) begin
              wbuf_nxt = 32'(in_data.message_byte);
            end else begin
              wbuf_nxt = wbuf_r | (32'(in_data.message_byte) << {pos[1:0], 3'b000});
            end
            mem_we    = (pos[1:0] == 2'd3);
            mem_waddr = pos[5:2];
            mem_wdata = wbuf_nxt;
            cnt_nxt   = cnt_r + 64'd1;
          end
          // end of message: set up padding
          if (in_data.last_byte) begin
            final_nxt  = 1'b1;
            pw_nxt     = cnt_nxt[5:2];
            pfirst_nxt = 1'b1;
            len_ok_nxt = (cnt_nxt[5:0] < md5_pkg::LEN_BYTE_POS);
          end
          if (in_data.byte_valid && pos == 6'd63) begin
            state_nxt = md5_pkg::ST_LOAD;
          end else if (in_data.last_byte) begin
            state_nxt = md5_pkg::ST_PAD;
          end
        end
      end

      md5_pkg::ST_LOAD: begin
        // copy chain into working words, fetch word of round 0
        rctrl.load = 1'b1;
        mem_raddr  = md5_pkg::msg_index(6'd0);
        rnd_nxt    = 6'd0;
        state_nxt  = md5_pkg::ST_ROUND;
      end

      md5_pkg::ST_ROUND: begin
        // one round; fetch the next round's word
        rctrl.step = 1'b1;
        mem_raddr  = md5_pkg::msg_index(rnd_r + 6'd1);
        rnd_nxt    = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = md5_pkg::ST_ADD;
        end
      end

      md5_pkg::ST_ADD: begin
        for (int i = 0; i < 4; i++) begin
          chain_nxt[i] = chain_r[i] + work[i];
        end
        if (!final_r) begin
          state_nxt = md5_pkg::ST_IDLE;
        end else if (pad_done_r) begin
          oidx_nxt  = 2'd0;
          state_nxt = md5_pkg::ST_OUT;
        end else begin
          // length did not fit: second padding block of zeros and length
          if (!len_ok_r) begin
            pw_nxt     = 4'd0;
            pfirst_nxt = 1'b0;
            len_ok_nxt = 1'b1;
          end
          state_nxt = md5_pkg::ST_PAD;
        end
      end

      md5_pkg::ST_PAD: begin
        // one padding word per cycle up to the end of the block
        mem_we     = 1'b1;
        mem_waddr  = pw_r;
        mem_wdata  = pad_word;
        pfirst_nxt = 1'b0;
        pw_nxt     = pw_r + 4'd1;
        if (pw_r == md5_pkg::LEN_WORD_HI) begin
          pad_done_nxt = len_ok_r;
          state_nxt    = md5_pkg::ST_LOAD;
        end
      end

      md5_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_acc) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            // re-arm for the next message
            for (int i = 0; i < 4; i++) begin
              chain_nxt[i] = md5_pkg::init_word(2'(i));
            end
            cnt_nxt      = 64'd0;
            final_nxt    = 1'b0;
            pad_done_nxt = 1'b0;
            state_nxt    = md5_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = md5_pkg::ST_IDLE;
      end
    endcase
  end

  // result item
  always_comb begin
    out_data.digest_word = chain_r[oidx_r];
    out_data.word_index  = oidx_r;
    out_data.last_word   = (oidx_r == 2'd3);
  end

  // control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= md5_pkg::ST_IDLE;
      cnt_r      <= 64'd0;
      rnd_r      <= 6'd0;
      pw_r       <= 4'd0;
      pfirst_r   <= 1'b0;
      len_ok_r   <= 1'b0;
      final_r    <= 1'b0;
      pad_done_r <= 1'b0;
      oidx_r     <= 2'd0;
      for (int i = 0; i < 4; i++) begin
        chain_r[i] <= md5_pkg::init_word(2'(i));
      end
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      rnd_r      <= rnd_nxt;
      pw_r       <= pw_nxt;
      pfirst_r   <= pfirst_nxt;
      len_ok_r   <= len_ok_nxt;
      final_r    <= final_nxt;
      pad_done_r <= pad_done_nxt;
      oidx_r     <= oidx_nxt;
      chain_r    <= chain_nxt;
    end
  end

  // word assembly register
  always_ff @(posedge clk) begin
    wbuf_r <= wbuf_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/md5_blk_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// md5_blk_mem
// 16 x 32 block buffer, one write port and one registered read port.
// ---------------------------------------------------------------------------
module md5_blk_mem (
  input  wire logic        clk,
  input  wire logic        wr_en,
  input  wire logic [3:0]  wr_addr,
  input  wire logic [31:0] wr_data,
  input  wire logic [3:0]  rd_addr,
  output logic      [31:0] rd_data
);

  logic [31:0] mem [16];
  logic [31:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hdl/md5_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// md5_round
// Working registers a, b, c, d and one MD5 round step per cycle while ctrl.step is high.
// ---------------------------------------------------------------------------
module md5_round (
  input  wire logic                 clk,
  input  wire md5_pkg::rnd_ctrl_t   ctrl,
  input  wire logic [3:0][31:0]     init_words,
  input  wire logic [31:0]          msg_word,
  output logic      [3:0][31:0]     work
);

  logic [3:0][31:0] work_r;
  logic [3:0][31:0] work_nxt;
  logic [1:0]       phase;
  logic [31:0]      f_val;
  logic [31:0]      sum;
  logic [31:0]      new_b;

  // round datapath
  always_comb begin
    phase = ctrl.rnd[5:4];
    f_val = md5_pkg::mix(phase, work_r[1], work_r[2], work_r[3]);
    sum   = work_r[0] + f_val + md5_pkg::round_k(ctrl.rnd) + msg_word;
    new_b = work_r[1] + md5_pkg::rotl32(sum, md5_pkg::round_shift(phase, ctrl.rnd[1:0]));
  end

  // load from chaining value or advance one round
  always_comb begin
    work_nxt = work_r;
    if (ctrl.load) begin
      work_nxt = init_words;
    end else if (ctrl.step) begin
      work_nxt[0] = work_r[3];
      work_nxt[1] = new_b;
      work_nxt[2] = work_r[1];
      work_nxt[3] = work_r[2];
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign work = work_r;

endmodule
`default_nettype wire
